// ===== src/bint_pkg.sv =====
// Shared types and constants of the bone influence table.
package bint_pkg;

    localparam int OP_W   = 2;
    localparam int VIDX_W = 10;
    localparam int BONE_W = 8;
    localparam int WT_W   = 16;
    localparam int STAT_W = 2;
    localparam int SLOT_W = 3;
    localparam int FILL_W = 4;
    // Sum of up to eight Q1.15 weights, plus one bit for the shifted remainder.
    localparam int ALU_W  = 20;

    localparam logic [WT_W-1:0] ONE_Q15 = 16'h8000;

    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_NORM = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    localparam logic [STAT_W-1:0] ST_STORED   = 2'd0;
    localparam logic [STAT_W-1:0] ST_REPLACED = 2'd1;
    localparam logic [STAT_W-1:0] ST_DROPPED  = 2'd2;
    localparam logic [STAT_W-1:0] ST_REPORT   = 2'd3;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             carry;
    } t_alu_rsp;

endpackage

// ===== src/bint_addsub.sv =====
// Shared add/subtract unit used for summing, minimum search, the replace decision and division steps.
module bint_addsub (
    input  bint_pkg::t_alu_req i_req,
    output bint_pkg::t_alu_rsp o_rsp
);
    import bint_pkg::*;

    logic [ALU_W:0]   w_sum;
    logic [ALU_W-1:0] w_b;

    // On subtract the carry out is high when a >= b.
    assign w_b   = i_req.sub ? ~i_req.b : i_req.b;
    assign w_sum = {1'b0, i_req.a} + {1'b0, w_b} + (ALU_W+1)'(i_req.sub);

    assign o_rsp.res   = w_sum[ALU_W-1:0];
    assign o_rsp.carry = w_sum[ALU_W];

endmodule

// ===== src/bint_row_mem.sv =====
// Single-port-write, single-port-read row memory with registered read data.
module bint_row_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 100,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bone_influence_table_unit.sv =====
// Top level of the bone influence table: sequencer, working row and output register.
//
// Input channel (i_valid/o_ready) carries one item: op, vertex_index, bone_id and
// weight_in. Output channel (o_valid/i_ready) carries result transfers: status, slot,
// slot_bone, slot_weight and last, with last high on the final result of an item.
// Each vertex occupies one memory row holding its fill count and all slots, so an
// item is one row read, work on a register copy, and at most one row write.
// One 20-bit add/subtract unit does the sum, the minimum search, the replace
// decision and a 16-step restoring division per slot; when a normalize finds
// the sum is zero, slot 0 is set to 1.0 and the division is skipped.
// An out-of-range vertex skips the row write-back; op 3 is taken and produces nothing.
// o_ready is high only while the sequencer is idle; a finished result waits in the
// output register, so the next item is taken while the receiver stalls, but the
// sequencer holds before emitting its own first result until that register frees.
// After reset a clearing pass writes zero to every row, one row per cycle;
// o_ready stays low until it ends.
module bone_influence_table_unit #(
    parameter int MAX_INFLUENCES = 4,
    parameter int VERTEX_COUNT   = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [bint_pkg::OP_W-1:0]    i_op,
    input  logic [bint_pkg::VIDX_W-1:0]  i_vertex_index,
    input  logic [bint_pkg::BONE_W-1:0]  i_bone_id,
    input  logic [bint_pkg::WT_W-1:0]    i_weight_in,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bint_pkg::STAT_W-1:0]  o_status,
    output logic [bint_pkg::SLOT_W-1:0]  o_slot,
    output logic [bint_pkg::BONE_W-1:0]  o_slot_bone,
    output logic [bint_pkg::WT_W-1:0]    o_slot_weight,
    output logic                         o_last
);
    import bint_pkg::*;

    localparam int K     = MAX_INFLUENCES;
    localparam int AW    = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int CW    = $clog2(K + 1);
    localparam int SW    = (K > 1) ? $clog2(K) : 1;
    localparam int ROW_W = FILL_W + K * (BONE_W + WT_W);

    typedef enum logic [11:0] {
        S_CLEAR    = 12'b0000_0000_0001,
        S_IDLE     = 12'b0000_0000_0010,
        S_LOAD     = 12'b0000_0000_0100,
        S_DISPATCH = 12'b0000_0000_1000,
        S_MIN      = 12'b0000_0001_0000,
        S_DECIDE   = 12'b0000_0010_0000,
        S_SUM      = 12'b0000_0100_0000,
        S_DINIT    = 12'b0000_1000_0000,
        S_DIV      = 12'b0001_0000_0000,
        S_WRITE    = 12'b0010_0000_0000,
        S_EMIT     = 12'b0100_0000_0000,
        S_REPORT   = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0] r_clr_addr, n_clr_addr;

    // Item captured at acceptance.
    logic [OP_W-1:0]   r_op;
    logic              r_vvalid;
    logic [AW-1:0]     r_addr;
    logic [BONE_W-1:0] r_bone_in;
    logic [WT_W-1:0]   r_w_in;

    // Working copy of one vertex row.
    logic [BONE_W-1:0] r_bone [K];
    logic [BONE_W-1:0] n_bone [K];
    logic [WT_W-1:0]   r_wt   [K];
    logic [WT_W-1:0]   n_wt   [K];
    logic [FILL_W-1:0] r_fill, n_fill;

    logic [CW-1:0]     r_cnt, n_cnt;
    logic [WT_W-1:0]   r_min_w, n_min_w;
    logic [SW-1:0]     r_min_slot, n_min_slot;
    logic [STAT_W-1:0] r_status, n_status;
    logic [ALU_W-1:0]  r_sum, n_sum;
    logic [ALU_W-1:0]  r_rem, n_rem;
    logic [WT_W-1:0]   r_quo, n_quo;
    logic [3:0]        r_bit, n_bit;

    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic [BONE_W-1:0] r_out_bone, n_out_bone;
    logic [WT_W-1:0]   r_out_wt, n_out_wt;
    logic              r_out_last, n_out_last;

    logic              w_accept;
    logic              w_out_free;
    logic [SW-1:0]     w_idx;
    logic [BONE_W-1:0] w_cur_bone;
    logic [WT_W-1:0]   w_cur_wt;
    logic [ALU_W-1:0]  w_rem_sel;
    logic [WT_W-1:0]   w_quo_next;

    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [ROW_W-1:0]  w_mem_wdata;
    logic [ROW_W-1:0]  w_row_pack;
    logic [ROW_W-1:0]  w_rd_data;
    logic [FILL_W-1:0] w_rd_fill;
    logic [BONE_W-1:0] w_rd_bone [K];
    logic [WT_W-1:0]   w_rd_wt   [K];

    t_alu_req w_alu_req;
    t_alu_rsp w_alu_rsp;

    bint_row_mem #(
        .DEPTH (VERTEX_COUNT),
        .WIDTH (ROW_W),
        .AW    (AW)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_accept),
        .i_raddr (AW'(i_vertex_index)),
        .o_rdata (w_rd_data)
    );

    bint_addsub u_addsub (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;

    assign w_idx      = r_cnt[SW-1:0];
    assign w_cur_bone = r_bone[w_idx];
    assign w_cur_wt   = r_wt[w_idx];

    // Row layout: fill count in the low bits, then all bone ids, then all weights.
    always_comb begin
        w_rd_fill  = w_rd_data[FILL_W-1:0];
        w_row_pack = '0;
        w_row_pack[FILL_W-1:0] = r_fill;
        for (int s = 0; s < K; s++) begin
            w_rd_bone[s] = w_rd_data[FILL_W + s*BONE_W +: BONE_W];
            w_rd_wt[s]   = w_rd_data[FILL_W + K*BONE_W + s*WT_W +: WT_W];
            w_row_pack[FILL_W + s*BONE_W +: BONE_W]      = r_bone[s];
            w_row_pack[FILL_W + K*BONE_W + s*WT_W +: WT_W] = r_wt[s];
        end
    end

    // Operand selection for the shared unit.
    always_comb begin
        w_alu_req = '0;
        unique case (r_state)
            S_SUM: begin
                w_alu_req.a   = r_sum;
                w_alu_req.b   = ALU_W'(w_cur_wt);
                w_alu_req.sub = 1'b0;
            end
            S_MIN: begin
                w_alu_req.a   = ALU_W'(w_cur_wt);
                w_alu_req.b   = ALU_W'(r_min_w);
                w_alu_req.sub = 1'b1;
            end
            S_DECIDE: begin
                // No carry means the minimum is below the new weight.
                w_alu_req.a   = ALU_W'(r_min_w);
                w_alu_req.b   = ALU_W'(r_w_in);
                w_alu_req.sub = 1'b1;
            end
            S_DIV: begin
                w_alu_req.a   = r_rem;
                w_alu_req.b   = r_sum;
                w_alu_req.sub = 1'b1;
            end
            default: begin
                w_alu_req = '0;
            end
        endcase
    end

    assign w_rem_sel  = w_alu_rsp.carry ? w_alu_rsp.res : r_rem;
    assign w_quo_next = {r_quo[WT_W-2:0], w_alu_rsp.carry};

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_bone       = r_bone;
        n_wt         = r_wt;
        n_fill       = r_fill;
        n_cnt        = r_cnt;
        n_min_w      = r_min_w;
        n_min_slot   = r_min_slot;
        n_status     = r_status;
        n_sum        = r_sum;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_bit        = r_bit;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_bone   = r_out_bone;
        n_out_wt     = r_out_wt;
        n_out_last   = r_out_last;
        w_mem_we     = 1'b0;
        w_mem_waddr  = r_addr;
        w_mem_wdata  = w_row_pack;

        unique case (r_state)
            S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr_addr;
                w_mem_wdata = '0;
                if (r_clr_addr == AW'(VERTEX_COUNT - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (w_accept && i_op != OP_NONE) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                for (int s = 0; s < K; s++) begin
                    n_bone[s] = r_vvalid ? w_rd_bone[s] : '0;
                    n_wt[s]   = r_vvalid ? w_rd_wt[s] : '0;
                end
                n_fill  = r_vvalid ? w_rd_fill : '0;
                n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                n_cnt = '0;
                if (r_op == OP_ADD) begin
                    if (!r_vvalid) begin
                        n_status = ST_DROPPED;
                        n_state  = S_EMIT;
                    end else if (r_fill < FILL_W'(K)) begin
                        n_bone[r_fill[SW-1:0]] = r_bone_in;
                        n_wt[r_fill[SW-1:0]]   = r_w_in;
                        n_fill   = r_fill + FILL_W'(1);
                        n_cnt    = CW'(r_fill);
                        n_status = ST_STORED;
                        n_state  = S_WRITE;
                    end else begin
                        n_min_w    = r_wt[0];
                        n_min_slot = '0;
                        n_cnt      = CW'(1);
                        n_state    = S_MIN;
                    end
                end else if (r_op == OP_NORM && r_vvalid) begin
                    n_sum   = '0;
                    n_state = S_SUM;
                end else begin
                    n_state = S_REPORT;
                end
            end
            S_MIN: begin
                if (r_cnt == CW'(K)) begin
                    n_state = S_DECIDE;
                end else begin
                    // Strictly lower only, so the first slot wins a tie.
                    if (!w_alu_rsp.carry) begin
                        n_min_w    = w_cur_wt;
                        n_min_slot = w_idx;
                    end
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_DECIDE: begin
                n_cnt = CW'(r_min_slot);
                if (!w_alu_rsp.carry) begin
                    n_bone[r_min_slot] = r_bone_in;
                    n_wt[r_min_slot]   = r_w_in;
                    n_status = ST_REPLACED;
                    n_state  = S_WRITE;
                end else begin
                    n_status = ST_DROPPED;
                    n_state  = S_EMIT;
                end
            end
            S_SUM: begin
                if (r_cnt == CW'(K)) begin
                    n_cnt = '0;
                    if (r_sum == '0) begin
                        n_wt[0] = ONE_Q15;
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_DINIT;
                    end
                end else begin
                    n_sum = w_alu_rsp.res;
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_DINIT: begin
                // The weight never exceeds the sum, so the top quotient bit comes first.
                n_rem   = ALU_W'(w_cur_wt);
                n_quo   = '0;
                n_bit   = 4'd15;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_quo = w_quo_next;
                n_rem = {w_rem_sel[ALU_W-2:0], 1'b0};
                n_bit = r_bit - 4'd1;
                if (r_bit == 4'd0) begin
                    n_wt[w_idx] = w_quo_next;
                    if (r_cnt == CW'(K - 1)) begin
                        n_state = S_WRITE;
                    end else begin
                        n_cnt   = r_cnt + CW'(1);
                        n_state = S_DINIT;
                    end
                end
            end
            S_WRITE: begin
                w_mem_we = 1'b1;
                if (r_op == OP_ADD) begin
                    n_state = S_EMIT;
                end else begin
                    n_cnt   = '0;
                    n_state = S_REPORT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_slot   = SLOT_W'(r_cnt);
                    n_out_bone   = w_cur_bone;
                    n_out_wt     = w_cur_wt;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_REPORT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_REPORT;
                    n_out_slot   = SLOT_W'(r_cnt);
                    n_out_bone   = w_cur_bone;
                    n_out_wt     = w_cur_wt;
                    n_out_last   = (r_cnt == CW'(K - 1));
                    if (r_cnt == CW'(K - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= i_op;
            r_vvalid  <= (32'(i_vertex_index) < 32'(VERTEX_COUNT));
            r_addr    <= AW'(i_vertex_index);
            r_bone_in <= i_bone_id;
            r_w_in    <= (i_weight_in > ONE_Q15) ? ONE_Q15 : i_weight_in;
        end
        r_bone       <= n_bone;
        r_wt         <= n_wt;
        r_fill       <= n_fill;
        r_cnt        <= n_cnt;
        r_min_w      <= n_min_w;
        r_min_slot   <= n_min_slot;
        r_status     <= n_status;
        r_sum        <= n_sum;
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_bit        <= n_bit;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_bone   <= n_out_bone;
        r_out_wt     <= n_out_wt;
        r_out_last   <= n_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_slot        = r_out_slot;
    assign o_slot_bone   = r_out_bone;
    assign o_slot_weight = r_out_wt;
    assign o_last        = r_out_last;

    // The memory is written only by the clearing pass and the row write-back.
    a_mem_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_state == S_CLEAR || r_state == S_WRITE))
        else $error("row memory written outside clearing or write-back");

    // A stored fill count never exceeds the slot count.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISPATCH && r_vvalid) |-> (r_fill <= FILL_W'(K)))
        else $error("fill count above slot count");

    // A normalized weight never exceeds 1.0.
    a_quotient_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_bit == 4'd0) |-> (w_quo_next <= ONE_Q15))
        else $error("normalized weight above 1.0");

    // Add results are single transfers and always end their item.
    a_add_result_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_REPORT) |-> r_out_last)
        else $error("add result without last");

endmodule

// ===== tb/tb_bone_influence_table_unit.sv =====
// Self-checking testbench for the bone influence table with a scoreboard-based predictor.
module tb_bone_influence_table_unit;
    import bint_pkg::*;

    localparam int K            = 4;
    localparam int VERTS        = 1024;
    localparam int HALF_CYCLE   = 6;
    localparam int LIMIT_CYCLES = 400000;
    // Longest item is a normalize; the settle time covers it with margin.
    localparam int SETTLE_CYCLES = 19 * K + 20;
    localparam int TARGET_ITEMS  = 200;
    localparam int MAX_PRINTED   = 40;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [BONE_W-1:0] bone;
        logic [WT_W-1:0]   weight;
        logic              last;
    } t_slot_result;

    typedef enum int {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_BLOCKY} t_stall_mode;

    class influence_ledger;
        logic [BONE_W-1:0] bone_mem [VERTS*K];
        logic [WT_W-1:0]   weight_mem [VERTS*K];
        int unsigned       fill [VERTS];
        t_slot_result      due [$];
        int                errors;

        function new();
            for (int a = 0; a < VERTS * K; a++) begin
                bone_mem[a]   = '0;
                weight_mem[a] = '0;
            end
            for (int v = 0; v < VERTS; v++) fill[v] = 0;
            errors = 0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void push(logic [STAT_W-1:0] status, int unsigned slot,
                           logic [BONE_W-1:0] bone, logic [WT_W-1:0] weight, logic last);
            t_slot_result r;
            r.status = status;
            r.slot   = slot[SLOT_W-1:0];
            r.bone   = bone;
            r.weight = weight;
            r.last   = last;
            due.push_back(r);
        endfunction

        function void push_slots(int unsigned base, bit in_range);
            for (int s = 0; s < K; s++)
                push(ST_REPORT, s, in_range ? bone_mem[base + s] : '0,
                     in_range ? weight_mem[base + s] : '0, s == K - 1);
        endfunction

        // Applies one accepted item to the table copy and queues what it reports.
        function void note_item(logic [OP_W-1:0] op, logic [VIDX_W-1:0] vidx,
                                logic [BONE_W-1:0] bone, logic [WT_W-1:0] wt_raw);
            int unsigned base, cnt, mslot, sum, x;
            logic [WT_W-1:0] wt, mw;
            bit in_range;
            in_range = vidx < VERTS;
            base     = in_range ? vidx * K : 0;
            wt       = (wt_raw > ONE_Q15) ? ONE_Q15 : wt_raw;
            case (op)
                OP_ADD: begin
                    if (!in_range) begin
                        push(ST_DROPPED, 0, '0, '0, 1'b1);
                    end else if (fill[vidx] < K) begin
                        cnt = fill[vidx];
                        bone_mem[base + cnt]   = bone;
                        weight_mem[base + cnt] = wt;
                        fill[vidx] = cnt + 1;
                        push(ST_STORED, cnt, bone, wt, 1'b1);
                    end else begin
                        // Lowest weight wins; a tie keeps the earlier slot.
                        mslot = 0;
                        mw    = weight_mem[base];
                        for (int s = 1; s < K; s++) begin
                            if (weight_mem[base + s] < mw) begin
                                mw    = weight_mem[base + s];
                                mslot = s;
                            end
                        end
                        if (wt > mw) begin
                            bone_mem[base + mslot]   = bone;
                            weight_mem[base + mslot] = wt;
                            push(ST_REPLACED, mslot, bone, wt, 1'b1);
                        end else begin
                            push(ST_DROPPED, mslot, bone_mem[base + mslot], mw, 1'b1);
                        end
                    end
                end
                OP_NORM: begin
                    if (in_range) begin
                        sum = 0;
                        for (int s = 0; s < K; s++) sum += weight_mem[base + s];
                        if (sum > 0) begin
                            for (int s = 0; s < K; s++) begin
                                x = weight_mem[base + s];
                                x = (x * 32'd32768) / sum;
                                weight_mem[base + s] = x[WT_W-1:0];
                            end
                        end else begin
                            weight_mem[base] = ONE_Q15;
                        end
                    end
                    push_slots(base, in_range);
                end
                OP_READ: push_slots(base, in_range);
                default: ;
            endcase
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_result(t_slot_result got);
            t_slot_result want;
            if (due.size() == 0) begin
                report_mismatch($sformatf("unexpected result for slot %0d", got.slot));
                return;
            end
            want = due.pop_front();
            check_field("status", got.status, want.status);
            check_field("slot", got.slot, want.slot);
            check_field("slot_bone", got.bone, want.bone);
            check_field("slot_weight", got.weight, want.weight);
            check_field("last", got.last, want.last);
        endtask
    endclass

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [OP_W-1:0]    i_op    = '0;
    logic [VIDX_W-1:0]  i_vertex_index = '0;
    logic [BONE_W-1:0]  i_bone_id      = '0;
    logic [WT_W-1:0]    i_weight_in    = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [STAT_W-1:0]  o_status;
    logic [SLOT_W-1:0]  o_slot;
    logic [BONE_W-1:0]  o_slot_bone;
    logic [WT_W-1:0]    o_slot_weight;
    logic               o_last;

    influence_ledger    ledger;
    int unsigned        items_sent;
    int unsigned        burst_left;
    t_stall_mode        stall_mode;
    int unsigned        stall_left;
    int unsigned        stall_phase;
    logic [VIDX_W-1:0]  hot [4];
    logic [VIDX_W-1:0]  v;
    logic [WT_W-1:0]    w;

    bone_influence_table_unit #(
        .MAX_INFLUENCES(K),
        .VERTEX_COUNT(VERTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_op(i_op),
        .i_vertex_index(i_vertex_index),
        .i_bone_id(i_bone_id),
        .i_weight_in(i_weight_in),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_status(o_status),
        .o_slot(o_slot),
        .o_slot_bone(o_slot_bone),
        .o_slot_weight(o_slot_weight),
        .o_last(o_last)
    );

    always #HALF_CYCLE i_clk = ~i_clk;

    // Sender pacing: bursts of back-to-back transfers separated by random gaps.
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic send_item(logic [OP_W-1:0] op, logic [VIDX_W-1:0] vidx,
                             logic [BONE_W-1:0] bone, logic [WT_W-1:0] wt);
        i_valid        <= 1'b1;
        i_op           <= op;
        i_vertex_index <= vidx;
        i_bone_id      <= bone;
        i_weight_in    <= wt;
        do @(posedge i_clk); while (!o_ready);
        ledger.note_item(op, vidx, bone, wt);
        if (op != OP_NONE) items_sent++;
        pace();
    endtask

    // Holds the sender off until every queued result has been seen.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (ledger.pending() != 0);
    endtask

    function automatic logic [WT_W-1:0] pick_weight(logic [WT_W-1:0] prev);
        case ($urandom_range(0, 7))
            0:       return prev;  // repeated weights create ties on the minimum
            1:       return '0;
            2:       return ONE_Q15;
            3:       return WT_W'($urandom_range(0, 255));
            4, 5:    return WT_W'($urandom_range(0, 32768));
            default: return WT_W'($urandom());
        endcase
    endfunction

    // Receiver: checks each transfer and stalls on a pattern that changes over time.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready)
            ledger.check_result(t_slot_result'{o_status, o_slot, o_slot_bone,
                                               o_slot_weight, o_last});
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 80);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            STALL_NONE:   i_ready <= 1'b1;
            STALL_COIN:   i_ready <= 1'($urandom_range(0, 1));
            STALL_SPARSE: i_ready <= (stall_phase % 4 == 0);
            default:      i_ready <= (stall_phase % 12 >= 8);
        endcase
    end

    initial begin
        ledger      = new();
        items_sent  = 0;
        burst_left  = 0;
        stall_left  = 0;
        stall_phase = 0;
        w           = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(OP_READ, 10'd0, 8'h00, 16'h0000);
        // A zero sum forces slot 0 to 1.0; the second pass sees a single weight.
        send_item(OP_NORM, 10'd1023, 8'h00, 16'h0000);
        send_item(OP_NORM, 10'd1023, 8'h00, 16'h0000);
        send_item(OP_ADD, 10'd1023, 8'hFF, ONE_Q15);
        send_item(OP_READ, 10'd1023, 8'hFF, 16'hFFFF);
        send_item(OP_ADD, 10'd5, 8'h00, 16'd100);
        send_item(OP_ADD, 10'd5, 8'hFF, 16'd0);
        send_item(OP_ADD, 10'd5, 8'hAA, 16'hFFFF);
        send_item(OP_ADD, 10'd5, 8'h55, 16'd100);
        send_item(OP_ADD, 10'd5, 8'h11, 16'd0);
        send_item(OP_ADD, 10'd5, 8'h22, 16'd50);
        send_item(OP_ADD, 10'd5, 8'h33, 16'd50);
        send_item(OP_ADD, 10'd5, 8'h44, 16'd51);
        send_item(OP_ADD, 10'd6, 8'h01, 16'd200);
        send_item(OP_ADD, 10'd6, 8'h02, 16'd100);
        send_item(OP_ADD, 10'd6, 8'h03, 16'd300);
        send_item(OP_ADD, 10'd6, 8'h04, 16'd100);
        send_item(OP_ADD, 10'd6, 8'h05, 16'd150);
        send_item(OP_NONE, 10'd6, 8'hFF, 16'hFFFF);
        send_item(OP_NORM, 10'd5, 8'h00, 16'h0000);
        send_item(OP_READ, 10'd5, 8'h00, 16'h0000);
        send_item(OP_NORM, 10'd6, 8'h00, 16'h0000);
        send_item(OP_ADD, 10'd0, 8'hFF, 16'h8001);
        drain();

        items_sent = 0;
        for (int h = 0; h < 4; h++) hot[h] = VIDX_W'($urandom_range(0, VERTS - 1));
        while (items_sent < TARGET_ITEMS) begin
            if ($urandom_range(0, 9) == 0) hot[$urandom_range(0, 3)] = VIDX_W'($urandom());
            v = hot[$urandom_range(0, 3)];
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
                    // Add weights to a vertex, which can fill it past capacity, then report it.
                    repeat ($urandom_range(1, 7)) begin
                        w = pick_weight(w);
                        send_item(OP_ADD, v, BONE_W'($urandom()), w);
                    end
                    send_item($urandom_range(0, 1) ? OP_NORM : OP_READ, v,
                              BONE_W'($urandom()), WT_W'($urandom()));
                end
                12, 13, 14, 15, 16: begin
                    send_item(OP_W'($urandom()),
                              ($urandom_range(0, 3) == 0) ? v : VIDX_W'($urandom()),
                              BONE_W'($urandom()), WT_W'($urandom()));
                end
                default: begin
                    send_item($urandom_range(0, 1) ? OP_NORM : OP_READ,
                              VIDX_W'($urandom()), BONE_W'($urandom()),
                              WT_W'($urandom()));
                end
            endcase
            if ($urandom_range(0, 29) == 0) drain();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (ledger.errors == 0 && ledger.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #(2 * HALF_CYCLE * LIMIT_CYCLES);
        $display("FAILURE");
        $finish;
    end

endmodule
